// ----- design/nmea_position_extractor_macros.svh -----
// Assertion helpers for the position extractor.
// Each helper is clocked on clk and disabled while rst_n is low.
`ifndef NMEA_POSITION_EXTRACTOR_MACROS_SVH
`define NMEA_POSITION_EXTRACTOR_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define NPE_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("npe assertion failed");

// Next-cycle implication.
`define NPE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("npe assertion failed");

`else

`define NPE_ASSERT_IMPL(lbl, ante, cons)
`define NPE_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- design/npe_pkg.sv -----
package npe_pkg;

    localparam int unsigned LINE_LIMIT  = 99;
    localparam int unsigned FRAC_DIGITS = 5;

    localparam int unsigned CNT_W   = 7;
    localparam int unsigned FLD_W   = 5;
    localparam int unsigned INT_W   = 17;
    localparam int unsigned FRAC_W  = 17;
    localparam int unsigned FD_W    = 3;
    localparam int unsigned TAG_W   = 24;
    localparam int unsigned LAT_W   = 30;
    localparam int unsigned LON_W   = 31;
    localparam int unsigned DEG_W   = 11;
    localparam int unsigned MM_W    = 7;
    localparam int unsigned FSC_W   = 24;
    localparam int unsigned DPART_W = 34;
    localparam int unsigned M_W     = 30;
    localparam int unsigned QUO_W   = 24;
    localparam int unsigned VAL_W   = 35;

    localparam logic [TAG_W-1:0] TAG_RMC = 24'h524D43;
    localparam logic [TAG_W-1:0] TAG_GGA = 24'h474741;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [FLD_W-1:0] FLD_MAX     = 5'd31;
    localparam logic [FLD_W-1:0] FLD_ADDR    = 5'd0;
    localparam logic [FLD_W-1:0] RMC_LAT_FLD = 5'd3;
    localparam logic [FLD_W-1:0] RMC_LON_FLD = 5'd5;
    localparam logic [FLD_W-1:0] GGA_LAT_FLD = 5'd2;
    localparam logic [FLD_W-1:0] GGA_LON_FLD = 5'd4;

    localparam logic [INT_W-1:0] INT_MAX_ACC = 17'd131071;
    localparam logic [LAT_W-1:0] LAT_MAX     = 30'd900000000;
    localparam logic [LON_W-1:0] LON_MAX     = 31'd1800000000;

    // x / 100 for x < 2^17: (x * 167773) >> 24
    localparam logic [17:0]     DIV100_MUL   = 18'd167773;
    localparam int unsigned     DIV100_SHIFT = 24;
    // m / 60 for m < 10^9: (m * 1145324613) >> 36
    localparam logic [30:0]     DIV60_MUL    = 31'd1145324613;
    localparam int unsigned     DIV60_SHIFT  = 36;
    localparam logic [FSC_W-1:0] E7          = 24'd10000000;
    localparam logic [6:0]      HUNDRED      = 7'd100;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_RMC  = 2'd1,
        KIND_GGA  = 2'd2
    } kind_t;

    // Control bits of one field-end request as it moves down the pipe.
    typedef struct packed {
        logic valid;
        logic conv_lat;
        logic conv_lon;
        logic emit;
        logic gga;
    } evt_ctl_t;

    // Raw ddmm.mmmmm digits of the field that just ended.
    typedef struct packed {
        logic [INT_W-1:0]  int_val;
        logic [FRAC_W-1:0] frac_val;
        logic [FD_W-1:0]   frac_digits;
    } num_t;

    // 10^(7 - fd): scales the fraction so that 10^7 / 10^fd stays integral.
    function automatic logic [FSC_W-1:0] frac_scale(input logic [FD_W-1:0] fd);
        logic [FSC_W-1:0] s;
        case (fd)
            3'd0:    s = 24'd10000000;
            3'd1:    s = 24'd1000000;
            3'd2:    s = 24'd100000;
            3'd3:    s = 24'd10000;
            3'd4:    s = 24'd1000;
            default: s = 24'd100;
        endcase
        return s;
    endfunction

endpackage

// ----- design/npe_parser.sv -----
module npe_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic               adv,
    input  logic [7:0]         rx_byte,
    output npe_pkg::evt_ctl_t  evt_ctl,
    output npe_pkg::num_t      evt_num
);
    import npe_pkg::*;

    logic [CNT_W-1:0]  char_count_reg,  char_count_next;
    logic [FLD_W-1:0]  field_index_reg, field_index_next;
    logic [TAG_W-1:0]  header_tail_reg, header_tail_next;
    kind_t             kind_seen_reg,   kind_seen_next;
    logic [INT_W-1:0]  int_accum_reg,   int_accum_next;
    logic [FRAC_W-1:0] frac_accum_reg,  frac_accum_next;
    logic [FD_W-1:0]   frac_digits_reg, frac_digits_next;
    logic              after_point_reg, after_point_next;
    evt_ctl_t          evt_ctl_reg,     evt_ctl_next;
    num_t              evt_num_reg;

    logic              is_lf, is_comma, is_digit, is_point, in_limit;
    kind_t             hdr_kind, kind_eff;
    logic [3:0]        digit;
    logic [INT_W+3:0]  int_mac;
    logic [FRAC_W+3:0] frac_mac;

    always_comb
    begin
        is_lf    = (rx_byte == CH_LF);
        is_comma = (rx_byte == CH_COMMA);
        is_point = (rx_byte == CH_POINT);
        is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
        in_limit = (char_count_reg < CNT_W'(LINE_LIMIT));
        digit    = 4'(rx_byte - CH_ZERO);
        int_mac  = ({4'b0, int_accum_reg} << 3) + ({4'b0, int_accum_reg} << 1)
                   + (INT_W+4)'(digit);
        frac_mac = ({4'b0, frac_accum_reg} << 3) + ({4'b0, frac_accum_reg} << 1)
                   + (FRAC_W+4)'(digit);

        if (header_tail_reg == TAG_RMC)
            hdr_kind = KIND_RMC;
        else if (header_tail_reg == TAG_GGA)
            hdr_kind = KIND_GGA;
        else
            hdr_kind = KIND_NONE;

        kind_eff = (field_index_reg == FLD_ADDR) ? hdr_kind : kind_seen_reg;

        // field-end request
        evt_ctl_next = '0;
        if (accept && (is_lf || (is_comma && in_limit)) && field_index_reg != FLD_ADDR)
        begin
            unique case (kind_seen_reg)
                KIND_RMC:
                begin
                    evt_ctl_next.conv_lat = (field_index_reg == RMC_LAT_FLD);
                    evt_ctl_next.conv_lon = (field_index_reg == RMC_LON_FLD);
                end
                KIND_GGA:
                begin
                    evt_ctl_next.conv_lat = (field_index_reg == GGA_LAT_FLD);
                    evt_ctl_next.conv_lon = (field_index_reg == GGA_LON_FLD);
                end
                default: ;
            endcase
        end
        evt_ctl_next.emit  = accept && is_lf && (kind_eff != KIND_NONE);
        evt_ctl_next.gga   = (kind_eff == KIND_GGA);
        evt_ctl_next.valid = evt_ctl_next.conv_lat || evt_ctl_next.conv_lon
                             || evt_ctl_next.emit;

        char_count_next  = char_count_reg;
        field_index_next = field_index_reg;
        header_tail_next = header_tail_reg;
        kind_seen_next   = kind_seen_reg;
        int_accum_next   = int_accum_reg;
        frac_accum_next  = frac_accum_reg;
        frac_digits_next = frac_digits_reg;
        after_point_next = after_point_reg;

        if (accept)
        begin
            if (is_lf)
            begin
                char_count_next  = '0;
                field_index_next = '0;
                header_tail_next = '0;
                kind_seen_next   = KIND_NONE;
                int_accum_next   = '0;
                frac_accum_next  = '0;
                frac_digits_next = '0;
                after_point_next = 1'b0;
            end
            else if (in_limit)
            begin
                char_count_next = char_count_reg + 1'b1;
                if (is_comma)
                begin
                    if (field_index_reg == FLD_ADDR)
                        kind_seen_next = hdr_kind;
                    if (field_index_reg != FLD_MAX)
                        field_index_next = field_index_reg + 1'b1;
                    int_accum_next   = '0;
                    frac_accum_next  = '0;
                    frac_digits_next = '0;
                    after_point_next = 1'b0;
                end
                else
                begin
                    if (field_index_reg == FLD_ADDR)
                        header_tail_next = {header_tail_reg[TAG_W-9:0], rx_byte};
                    if (is_digit)
                    begin
                        if (!after_point_reg)
                        begin
                            int_accum_next = (int_mac > (INT_W+4)'(INT_MAX_ACC))
                                             ? INT_MAX_ACC : int_mac[INT_W-1:0];
                        end
                        else if (frac_digits_reg < FD_W'(FRAC_DIGITS))
                        begin
                            frac_accum_next  = frac_mac[FRAC_W-1:0];
                            frac_digits_next = frac_digits_reg + 1'b1;
                        end
                    end
                    else if (is_point)
                    begin
                        after_point_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_count_reg  <= '0;
            field_index_reg <= '0;
            header_tail_reg <= '0;
            kind_seen_reg   <= KIND_NONE;
            int_accum_reg   <= '0;
            frac_accum_reg  <= '0;
            frac_digits_reg <= '0;
            after_point_reg <= 1'b0;
            evt_ctl_reg     <= '0;
        end
        else
        begin
            char_count_reg  <= char_count_next;
            field_index_reg <= field_index_next;
            header_tail_reg <= header_tail_next;
            kind_seen_reg   <= kind_seen_next;
            int_accum_reg   <= int_accum_next;
            frac_accum_reg  <= frac_accum_next;
            frac_digits_reg <= frac_digits_next;
            after_point_reg <= after_point_next;
            if (adv)
                evt_ctl_reg <= evt_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            evt_num_reg.int_val     <= int_accum_reg;
            evt_num_reg.frac_val    <= frac_accum_reg;
            evt_num_reg.frac_digits <= frac_digits_reg;
        end
    end

    assign evt_ctl = evt_ctl_reg;
    assign evt_num = evt_num_reg;

endmodule

// ----- design/npe_convert.sv -----
module npe_convert (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  npe_pkg::evt_ctl_t           in_ctl,
    input  npe_pkg::num_t               in_num,
    output npe_pkg::evt_ctl_t           out_ctl,
    output logic [npe_pkg::VAL_W-1:0]   out_value
);
    import npe_pkg::*;

    evt_ctl_t           ctl2_reg, ctl3_reg, ctl4_reg, ctl5_reg;
    logic [INT_W-1:0]   int2_reg;
    logic [DEG_W-1:0]   deg2_reg;
    logic [FSC_W-1:0]   fsc2_reg, fsc3_reg;
    logic [MM_W-1:0]    mm3_reg;
    logic [DPART_W-1:0] dpart3_reg, dpart4_reg, dpart5_reg;
    logic [M_W-1:0]     m4_reg;
    logic [QUO_W-1:0]   quo5_reg;

    logic [INT_W+17:0]  deg_prod;
    logic [FRAC_W+FSC_W-1:0] fsc_prod;
    logic [INT_W-1:0]   mm_full;
    logic [M_W+30:0]    quo_prod;

    always_comb
    begin
        // degrees = ddmm / 100, fraction scaled to 10^-7 minute units
        deg_prod = (INT_W+18)'(in_num.int_val) * (INT_W+18)'(DIV100_MUL);
        fsc_prod = (FRAC_W+FSC_W)'(in_num.frac_val)
                   * (FRAC_W+FSC_W)'(frac_scale(in_num.frac_digits));
        mm_full  = int2_reg - INT_W'(INT_W'(deg2_reg) * INT_W'(HUNDRED));
        quo_prod = (M_W+31)'(m4_reg) * (M_W+31)'(DIV60_MUL);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
            ctl5_reg <= '0;
        end
        else if (adv)
        begin
            ctl2_reg <= in_ctl;
            ctl3_reg <= ctl2_reg;
            ctl4_reg <= ctl3_reg;
            ctl5_reg <= ctl4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            int2_reg   <= in_num.int_val;
            deg2_reg   <= deg_prod[DIV100_SHIFT +: DEG_W];
            fsc2_reg   <= fsc_prod[FSC_W-1:0];
            mm3_reg    <= mm_full[MM_W-1:0];
            dpart3_reg <= DPART_W'(deg2_reg) * DPART_W'(E7);
            fsc3_reg   <= fsc2_reg;
            m4_reg     <= M_W'(mm3_reg) * M_W'(E7) + M_W'(fsc3_reg);
            dpart4_reg <= dpart3_reg;
            quo5_reg   <= quo_prod[DIV60_SHIFT +: QUO_W];
            dpart5_reg <= dpart4_reg;
        end
    end

    assign out_ctl   = ctl5_reg;
    assign out_value = VAL_W'(dpart5_reg) + VAL_W'(quo5_reg);

endmodule

// ----- design/nmea_position_extractor.sv -----
// NMEA position extractor: RMC and GGA latitude and longitude to 1e-7 degree.
// Throughput: one received byte per cycle; in_ready drops only while a result
// sits unclaimed in the output register and another one is at the pipe's end.
// Path: a line feed's request is registered in the parser, moves through the conversion pipe
// (divide by 100, scale, divide by 60) and then loads the output register that drives out_valid.
// Reset: asynchronous, active low; clears line state, both latches and all valid bits.
module nmea_position_extractor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [29:0] lat_e7,
    output logic [30:0] lon_e7,
    output logic        sentence_kind,
    output logic        fix_valid
);
    import npe_pkg::*;

    `include "nmea_position_extractor_macros.svh"

    // Pipe control: the whole pipe moves together. It holds only when the
    // request at its end carries a result and the output register is still full.
    logic            adv;
    logic            accept;

    evt_ctl_t        p1_ctl;
    num_t            p1_num;
    evt_ctl_t        fin_ctl;
    logic [VAL_W-1:0] fin_value;

    logic [LAT_W-1:0] lat_latch_reg, lat_new;
    logic [LON_W-1:0] lon_latch_reg, lon_new;
    logic [LAT_W-1:0] lat_sat;
    logic [LON_W-1:0] lon_sat;
    logic             load_out;

    logic             out_valid_reg;
    logic [LAT_W-1:0] lat_out_reg;
    logic [LON_W-1:0] lon_out_reg;
    logic             kind_out_reg;
    logic             fix_out_reg;

    assign adv      = !(fin_ctl.valid && fin_ctl.emit && out_valid_reg && !out_ready);
    assign in_ready = adv;
    assign accept   = in_valid && in_ready;

    // Front end: splits lines into fields and issues a request at each field end
    // that touches a latch or closes a known sentence.
    npe_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .adv     (adv),
        .rx_byte (rx_byte),
        .evt_ctl (p1_ctl),
        .evt_num (p1_num)
    );

    // ddmm.mmmmm to degrees * 10^7, before saturation.
    npe_convert u_convert (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_ctl    (p1_ctl),
        .in_num    (p1_num),
        .out_ctl   (fin_ctl),
        .out_value (fin_value)
    );

    always_comb
    begin
        // Clamp out-of-range coordinates.
        lat_sat = (fin_value > VAL_W'(LAT_MAX)) ? LAT_MAX : fin_value[LAT_W-1:0];
        lon_sat = (fin_value > VAL_W'(LON_MAX)) ? LON_MAX : fin_value[LON_W-1:0];

        // A line feed can close the longitude field and report in one request,
        // so the result sees the freshly converted value.
        lat_new = (fin_ctl.valid && fin_ctl.conv_lat) ? lat_sat : lat_latch_reg;
        lon_new = (fin_ctl.valid && fin_ctl.conv_lon) ? lon_sat : lon_latch_reg;

        load_out = adv && fin_ctl.valid && fin_ctl.emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lat_latch_reg <= '0;
            lon_latch_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                lat_latch_reg <= lat_new;
                lon_latch_reg <= lon_new;
            end
            // Drop the taken result, then load a new one if it arrives.
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            lat_out_reg  <= lat_new;
            lon_out_reg  <= lon_new;
            kind_out_reg <= fin_ctl.gga;
            fix_out_reg  <= (lat_new != '0) && (lon_new != '0);
        end
    end

    assign out_valid     = out_valid_reg;
    assign lat_e7        = lat_out_reg;
    assign lon_e7        = lon_out_reg;
    assign sentence_kind = kind_out_reg;
    assign fix_valid     = fix_out_reg;

    `NPE_ASSERT_IMPL(a_fix_matches, out_valid, fix_valid == ((lat_e7 != '0) && (lon_e7 != '0)))
    `NPE_ASSERT_IMPL(a_range, out_valid, (lat_e7 <= LAT_MAX) && (lon_e7 <= LON_MAX))
    `NPE_ASSERT_NEXT(a_result_lands, load_out, out_valid)
    `NPE_ASSERT_IMPL(a_no_overwrite, out_valid && !out_ready && fin_ctl.valid && fin_ctl.emit, !in_ready)

endmodule
